FILE: hdl/ted_pkg.sv
`timescale 1ns / 1ps
// shared widths, codes, item structs and the byte classifier for the encoding sniffer
package ted_pkg;

    localparam int COUNT_W     = 27;
    localparam int LONE_W      = 26;
    localparam int BAD_W       = COUNT_W + 1;
    localparam int PROD_W      = BAD_W + 7;
    localparam int QUEUE_DEPTH = 4;

    typedef logic [2:0] enc_t;

    localparam enc_t ENC_UNKNOWN  = 3'd0;
    localparam enc_t ENC_UTF8_BOM = 3'd1;
    localparam enc_t ENC_UTF32LE  = 3'd2;
    localparam enc_t ENC_UTF32BE  = 3'd3;
    localparam enc_t ENC_UTF16LE  = 3'd4;
    localparam enc_t ENC_UTF16BE  = 3'd5;
    localparam enc_t ENC_UTF8     = 3'd6;
    localparam enc_t ENC_ANSI     = 3'd7;

    typedef logic [2:0] cls_t;

    localparam cls_t CLS_ASCII   = 3'd0;
    localparam cls_t CLS_CONT    = 3'd1;
    localparam cls_t CLS_LEAD2   = 3'd2;
    localparam cls_t CLS_LEAD3   = 3'd3;
    localparam cls_t CLS_LEAD4   = 3'd4;
    localparam cls_t CLS_INVALID = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last;
        cls_t       cls;
        logic       is_zero;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] len;
        logic [3:0][7:0]    head;
        logic [LONE_W-1:0]  lone;
        logic [COUNT_W-1:0] invalid;
        logic               open_seq;
    } snap_t;

    function automatic cls_t classify(input logic [7:0] b);
        cls_t c;
        if (b[7] == 1'b0) begin
            c = CLS_ASCII;
        end else if ((b & 8'hC0) == 8'h80) begin
            c = CLS_CONT;
        end else if ((b & 8'hE0) == 8'hC0) begin
            c = CLS_LEAD2;
        end else if ((b & 8'hF0) == 8'hE0) begin
            c = CLS_LEAD3;
        end else if ((b & 8'hF8) == 8'hF0) begin
            c = CLS_LEAD4;
        end else begin
            c = CLS_INVALID;
        end
        return c;
    endfunction

endpackage

FILE: hdl/ted_front.sv
`timescale 1ns / 1ps
// input stage: accepts bytes and registers them with their utf-8 class
module ted_front
    import ted_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_byte_present,
    input  logic       s_last,
    output logic       out_valid,
    input  logic       out_ready,
    output item_t      out_item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_ready   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.data_byte    <= s_data_byte;
            item_reg.byte_present <= s_byte_present;
            item_reg.last         <= s_last;
            item_reg.cls          <= classify(s_data_byte);
            item_reg.is_zero      <= (s_data_byte == 8'h00);
        end
    end

endmodule

FILE: hdl/ted_queue.sv
`timescale 1ns / 1ps
// short fifo of classified items between the front and back ends
module ted_queue
    import ted_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

FILE: hdl/ted_back.sv
`timescale 1ns / 1ps
// back end: per-byte statistics, snapshot handed off at the end of a buffer
module ted_back
    import ted_pkg::*;
#(
    parameter int MAX_BYTES = 104857600
)
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  snap_valid,
    input  logic  snap_ready,
    output snap_t snap
);

    logic [COUNT_W-1:0] count_reg,   count_next;
    logic [3:0][7:0]    head_reg,    head_next;
    logic               pz_reg,      pz_next;
    logic [LONE_W-1:0]  lone_reg,    lone_next;
    logic [1:0]         skip_reg,    skip_next;
    logic               seqbad_reg,  seqbad_next;
    logic [COUNT_W-1:0] invalid_reg, invalid_next;
    logic               take;
    logic               use_byte;

    // an end item waits until the decision pipe can take the snapshot
    assign in_ready   = !in_item.last || snap_ready;
    assign take       = in_valid && in_ready;
    assign snap_valid = in_valid && in_item.last;
    assign use_byte   = in_item.byte_present && (count_reg < COUNT_W'(MAX_BYTES));

    always_comb begin
        count_next   = count_reg;
        head_next    = head_reg;
        pz_next      = pz_reg;
        lone_next    = lone_reg;
        skip_next    = skip_reg;
        seqbad_next  = seqbad_reg;
        invalid_next = invalid_reg;
        if (use_byte) begin
            if (count_reg < COUNT_W'(4)) begin
                head_next[count_reg[1:0]] = in_item.data_byte;
            end
            if (!count_reg[0]) begin
                pz_next = in_item.is_zero;
            end else if (pz_reg != in_item.is_zero) begin
                lone_next = lone_reg + 1'b1;
            end
            if (skip_reg != 2'd0) begin
                if (in_item.cls != CLS_CONT) begin
                    seqbad_next = 1'b1;
                end
                skip_next = skip_reg - 2'd1;
                if (skip_next == 2'd0 && seqbad_next) begin
                    invalid_next = invalid_reg + 1'b1;
                    seqbad_next  = 1'b0;
                end
            end else begin
                unique case (in_item.cls)
                    CLS_ASCII: begin
                    end
                    CLS_LEAD2: begin
                        skip_next   = 2'd1;
                        seqbad_next = 1'b0;
                    end
                    CLS_LEAD3: begin
                        skip_next   = 2'd2;
                        seqbad_next = 1'b0;
                    end
                    CLS_LEAD4: begin
                        skip_next   = 2'd3;
                        seqbad_next = 1'b0;
                    end
                    default: begin
                        invalid_next = invalid_reg + 1'b1;
                    end
                endcase
            end
            count_next = count_reg + 1'b1;
        end
    end

    assign snap.len      = count_next;
    assign snap.head     = head_next;
    assign snap.lone     = lone_next;
    assign snap.invalid  = invalid_next;
    assign snap.open_seq = (skip_next != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && in_item.last)) begin
            count_reg   <= '0;
            head_reg    <= '0;
            pz_reg      <= 1'b0;
            lone_reg    <= '0;
            skip_reg    <= 2'd0;
            seqbad_reg  <= 1'b0;
            invalid_reg <= '0;
        end else if (take) begin
            count_reg   <= count_next;
            head_reg    <= head_next;
            pz_reg      <= pz_next;
            lone_reg    <= lone_next;
            skip_reg    <= skip_next;
            seqbad_reg  <= seqbad_next;
            invalid_reg <= invalid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        take && in_item.last |=> count_reg == '0 && skip_reg == 2'd0 && invalid_reg == '0)
        else $error("statistics not cleared after end of buffer");

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_BYTES))
        else $error("byte count passed the size limit");
`endif

endmodule

FILE: hdl/ted_decide.sv
`timescale 1ns / 1ps
// three-stage decision pipe: bom and utf-16 checks, invalid ratio, output register
module ted_decide
    import ted_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  snap_valid,
    output logic  snap_ready,
    input  snap_t snap,
    output logic  m_valid,
    input  logic  m_ready,
    output enc_t  m_encoding_code
);

    logic               v1_reg, v2_reg, v3_reg;
    logic               rdy1, rdy2, rdy3;
    snap_t              s1_reg;
    logic               hit2_reg;
    enc_t               code2_reg;
    logic [PROD_W-1:0]  prod2_reg;
    logic [COUNT_W-1:0] len2_reg;
    enc_t               code3_reg;

    logic               pre_hit;
    enc_t               pre_code;
    logic [BAD_W-1:0]   bad;
    logic [PROD_W-1:0]  prod;
    logic [3:0][7:0]    h;
    logic [COUNT_W-1:0] len;

    assign rdy3       = !v3_reg || m_ready;
    assign rdy2       = !v2_reg || rdy3;
    assign rdy1       = !v1_reg || rdy2;
    assign snap_ready = rdy1;

    assign h   = s1_reg.head;
    assign len = s1_reg.len;

    always_comb begin
        pre_hit  = 1'b1;
        pre_code = ENC_UNKNOWN;
        if (len == '0) begin
            pre_code = ENC_UNKNOWN;
        end else if (len >= COUNT_W'(3) && h[0] == 8'hEF && h[1] == 8'hBB && h[2] == 8'hBF) begin
            pre_code = ENC_UTF8_BOM;
        end else if (len >= COUNT_W'(4) && h[0] == 8'hFF && h[1] == 8'hFE
                     && h[2] == 8'h00 && h[3] == 8'h00) begin
            pre_code = ENC_UTF32LE;
        end else if (len >= COUNT_W'(4) && h[0] == 8'h00 && h[1] == 8'h00
                     && h[2] == 8'hFE && h[3] == 8'hFF) begin
            pre_code = ENC_UTF32BE;
        end else if (len >= COUNT_W'(2) && h[0] == 8'hFF && h[1] == 8'hFE) begin
            pre_code = ENC_UTF16LE;
        end else if (len >= COUNT_W'(2) && h[0] == 8'hFE && h[1] == 8'hFF) begin
            pre_code = ENC_UTF16BE;
        end else if (len > COUNT_W'(10) && COUNT_W'(s1_reg.lone) > (len >> 4)
                     && h[0] != 8'h00 && h[1] == 8'h00) begin
            pre_code = ENC_UTF16LE;
        end else if (len > COUNT_W'(10) && COUNT_W'(s1_reg.lone) > (len >> 4)
                     && h[0] == 8'h00 && h[1] != 8'h00) begin
            pre_code = ENC_UTF16BE;
        end else begin
            pre_hit = 1'b0;
        end
    end

    // a sequence still open at the end counts as one more invalid
    assign bad  = BAD_W'(s1_reg.invalid) + BAD_W'(s1_reg.open_seq);
    assign prod = PROD_W'(bad) * PROD_W'(100);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= snap_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_valid && rdy1) begin
            s1_reg <= snap;
        end
        if (v1_reg && rdy2) begin
            hit2_reg  <= pre_hit;
            code2_reg <= pre_code;
            prod2_reg <= prod;
            len2_reg  <= len;
        end
        if (v2_reg && rdy3) begin
            if (hit2_reg) begin
                code3_reg <= code2_reg;
            end else if (prod2_reg < PROD_W'(len2_reg)) begin
                code3_reg <= ENC_UTF8;
            end else begin
                code3_reg <= ENC_ANSI;
            end
        end
    end

    assign m_valid         = v3_reg;
    assign m_encoding_code = code3_reg;

endmodule

FILE: hdl/text_encoding_detector_core.sv
`timescale 1ns / 1ps
// Encoding sniffer: takes one byte per cycle unless stalled; gives one code per buffer.
// A buffer is a run of items closed by one with s_last high; that item's byte, when
// s_byte_present is high, is counted first. Bytes past MAX_BYTES are ignored. Codes:
// 0 unknown (empty), 1 utf-8 bom, 2 utf-32 le, 3 utf-32 be, 4 utf-16 le, 5 utf-16 be,
// 6 utf-8, 7 ansi. The byte statistics update once per item in the back end, which
// sets the one-item-per-cycle rate; m_valid rises after the closing item is accepted
// and has passed the input register, four-entry queue and three-stage decision pipe,
// and the next buffer's bytes are taken meanwhile. No clearing pass after reset.
module text_encoding_detector_core
    import ted_pkg::*;
#(
    parameter int MAX_BYTES = 104857600
)
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_byte_present,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_encoding_code
);

    item_t front_item;
    logic  front_valid;
    logic  front_ready;
    item_t queue_item;
    logic  queue_valid;
    logic  queue_ready;
    snap_t snap;
    logic  snap_valid;
    logic  snap_ready;

    ted_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_byte_present (s_byte_present),
        .s_last         (s_last),
        .out_valid      (front_valid),
        .out_ready      (front_ready),
        .out_item       (front_item)
    );

    ted_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    ted_back #(
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (queue_valid),
        .in_ready   (queue_ready),
        .in_item    (queue_item),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    ted_decide u_decide (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .snap_valid      (snap_valid),
        .snap_ready      (snap_ready),
        .snap            (snap),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_encoding_code (m_encoding_code)
    );

endmodule

FILE: sim/text_encoding_detector_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the text encoding sniffer: random byte buffers, predicted codes
module text_encoding_detector_core_tb;
    import ted_pkg::*;

    localparam int MAX_LEN      = 128;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int ITEM_TARGET  = 800;
    localparam int TX           = 0;
    localparam int RX           = 1;
    localparam int END_ON_BYTE  = 0;
    localparam int END_MARKER   = 1;

    typedef enum int {
        BUF_TEXT,
        BUF_WIDE_LE,
        BUF_WIDE_BE,
        BUF_NOISE,
        BUF_BOM,
        BUF_LONG
    } buf_kind_t;

    // predicts the code of each buffer and checks the codes that come out
    class enc_scoreboard;
        logic [7:0]         head [4];
        logic [COUNT_W-1:0] nbytes;
        logic [7:0]         pair_lead;
        logic [LONE_W-1:0]  lone_pairs;
        logic [1:0]         skip_left;
        logic               seq_broken;
        logic [COUNT_W-1:0] bad_seqs;
        enc_t               code_q [$];
        int                 errors;
        int                 checked;
        int                 code_hits [8];

        function new();
            errors  = 0;
            checked = 0;
            foreach (code_hits[i]) code_hits[i] = 0;
            clear_stats();
        endfunction

        function void clear_stats();
            foreach (head[i]) head[i] = 8'h00;
            nbytes     = '0;
            pair_lead  = 8'h00;
            lone_pairs = '0;
            skip_left  = 2'd0;
            seq_broken = 1'b0;
            bad_seqs   = '0;
        endfunction

        function void absorb(input logic [7:0] b);
            logic [COUNT_W-1:0] pos;
            pos = nbytes;
            if (pos < 4) head[pos[1:0]] = b;
            // pairs start at even positions; only complete pairs count
            if (!pos[0]) begin
                pair_lead = b;
            end else if ((pair_lead == 8'h00) != (b == 8'h00)) begin
                lone_pairs = lone_pairs + 1'b1;
            end
            if (skip_left != 2'd0) begin
                if ((b & 8'hC0) != 8'h80) seq_broken = 1'b1;
                skip_left = skip_left - 2'd1;
                if (skip_left == 2'd0 && seq_broken) begin
                    bad_seqs   = bad_seqs + 1'b1;
                    seq_broken = 1'b0;
                end
            end else if (!b[7]) begin
                // plain ascii
            end else if ((b & 8'hE0) == 8'hC0) begin
                skip_left  = 2'd1;
                seq_broken = 1'b0;
            end else if ((b & 8'hF0) == 8'hE0) begin
                skip_left  = 2'd2;
                seq_broken = 1'b0;
            end else if ((b & 8'hF8) == 8'hF0) begin
                skip_left  = 2'd3;
                seq_broken = 1'b0;
            end else begin
                bad_seqs = bad_seqs + 1'b1;
            end
            nbytes = pos + 1'b1;
        endfunction

        function enc_t decide();
            longint len;
            longint bad;
            len = longint'(nbytes);
            bad = longint'(bad_seqs);
            if (len == 0) return ENC_UNKNOWN;
            if (len >= 3 && head[0] == 8'hEF && head[1] == 8'hBB && head[2] == 8'hBF)
                return ENC_UTF8_BOM;
            if (len >= 4 && head[0] == 8'hFF && head[1] == 8'hFE && head[2] == 8'h00 &&
                head[3] == 8'h00)
                return ENC_UTF32LE;
            if (len >= 4 && head[0] == 8'h00 && head[1] == 8'h00 && head[2] == 8'hFE &&
                head[3] == 8'hFF)
                return ENC_UTF32BE;
            if (len >= 2 && head[0] == 8'hFF && head[1] == 8'hFE) return ENC_UTF16LE;
            if (len >= 2 && head[0] == 8'hFE && head[1] == 8'hFF) return ENC_UTF16BE;
            if (len > 10 && longint'(lone_pairs) > len / 16) begin
                if (head[0] != 8'h00 && head[1] == 8'h00) return ENC_UTF16LE;
                if (head[0] == 8'h00 && head[1] != 8'h00) return ENC_UTF16BE;
            end
            // a sequence still open at the end is one more bad one
            if (skip_left != 2'd0) bad++;
            if (bad * 100 < len) return ENC_UTF8;
            return ENC_ANSI;
        endfunction

        function void note_error(input string msg);
            errors++;
            if (errors <= 10) $display("%0t ns: %s", $time, msg);
        endfunction

        function void note_item(input logic [7:0] b, input logic present, input logic l);
            if (present && nbytes < MAX_LEN) absorb(b);
            if (l) begin
                code_q.push_back(decide());
                clear_stats();
            end
        endfunction

        function void check_code(input enc_t got);
            enc_t want;
            if (code_q.size() == 0) begin
                note_error($sformatf("code %0d with no buffer closed", got));
                return;
            end
            want = code_q.pop_front();
            checked++;
            if (got !== want) begin
                note_error($sformatf("code mismatch: expected %0d, got %0d", want, got));
            end else begin
                code_hits[want]++;
            end
        endfunction

        function int pending();
            return code_q.size();
        endfunction
    endclass

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic [7:0] s_data_byte    = 8'h00;
    logic       s_byte_present = 1'b0;
    logic       s_last         = 1'b0;
    logic       m_ready        = 1'b0;
    wire        s_ready;
    wire        m_valid;
    wire  [2:0] m_encoding_code;

    enc_scoreboard sb;
    logic [7:0]    buf_q [$];
    int            quiet [2];
    int            rx_wait      = 0;
    int            hold_left    = 0;
    int            items_sent   = 0;
    int            stall_cycles = 0;

    text_encoding_detector_core #(
        .MAX_BYTES(MAX_LEN)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_byte_present  (s_byte_present),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_encoding_code (m_encoding_code)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // idle cycles before the next item, with occasional runs of back-to-back traffic
    function automatic int draw_gap(input int side);
        if (quiet[side] > 0) begin
            quiet[side]--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) quiet[side] = $urandom_range(15, 50);
        return $urandom_range(0, 16);
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_item(s_data_byte, s_byte_present, s_last);
            if (s_valid && !s_ready) stall_cycles++;
            if (m_valid && m_ready) begin
                sb.check_code(m_encoding_code);
                rx_wait = draw_gap(RX);
            end
        end
    end

    // result side: long hold first, then the per-item wait
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (rx_wait > 0) begin
            m_ready <= 1'b0;
            rx_wait--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_item(input logic [7:0] b, input logic present, input logic l,
                             input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= b;
        s_byte_present <= present;
        s_last         <= l;
        do @(posedge aclk); while (!s_ready);
        if (present || l) items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_buffer(input int end_style, input bit noisy);
        int n;
        n = buf_q.size();
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_item(8'($urandom), 1'b0, 1'b0, draw_gap(TX));
            send_item(buf_q[i], 1'b1, (end_style == END_ON_BYTE) && (i == n - 1),
                      draw_gap(TX));
        end
        if (end_style == END_MARKER || n == 0)
            send_item(8'($urandom), 1'b0, 1'b1, draw_gap(TX));
    endtask

    // utf-8 style text; err_pct of the picks are broken or stray bytes
    task automatic push_text(input int n, input int err_pct);
        int target;
        int r;
        int extra;
        target = buf_q.size() + n;
        while (buf_q.size() < target) begin
            r = $urandom_range(0, 99);
            extra = 0;
            if (r < err_pct) begin
                case ($urandom_range(0, 2))
                    0: buf_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                    1: buf_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
                    default: begin
                        buf_q.push_back(8'($urandom_range(8'hC0, 8'hF7)));
                        buf_q.push_back(8'($urandom_range(8'h00, 8'h7F)));
                    end
                endcase
            end else if (r < 60) begin
                buf_q.push_back(8'($urandom_range(8'h00, 8'h7F)));
            end else if (r < 75) begin
                buf_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                extra = 1;
            end else if (r < 88) begin
                buf_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                extra = 2;
            end else begin
                buf_q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
                extra = 3;
            end
            repeat (extra) buf_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        // chopping at the target leaves some sequences cut short
        while (buf_q.size() > target) buf_q.delete(buf_q.size() - 1);
    endtask

    task automatic build_buffer();
        buf_kind_t kind;
        int        r;
        int        n;
        logic [7:0] ch;
        r = $urandom_range(0, 24);
        if (r < 9)       kind = BUF_TEXT;
        else if (r < 13) kind = BUF_WIDE_LE;
        else if (r < 17) kind = BUF_WIDE_BE;
        else if (r < 20) kind = BUF_NOISE;
        else if (r < 24) kind = BUF_BOM;
        else             kind = BUF_LONG;
        buf_q.delete();
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 24);
        case (kind)
            BUF_TEXT: push_text(n, $urandom_range(0, 1) ? 0 : 6);
            BUF_WIDE_LE, BUF_WIDE_BE: begin
                if ($urandom_range(0, 2) == 0) begin
                    buf_q.push_back(kind == BUF_WIDE_LE ? 8'hFF : 8'hFE);
                    buf_q.push_back(kind == BUF_WIDE_LE ? 8'hFE : 8'hFF);
                end
                repeat ($urandom_range(4, 16)) begin
                    ch = 8'($urandom_range(1, 127));
                    if ($urandom_range(0, 9) == 0) begin
                        buf_q.push_back(8'($urandom));
                        buf_q.push_back(8'($urandom));
                    end else if (kind == BUF_WIDE_LE) begin
                        buf_q.push_back(ch);
                        buf_q.push_back(8'h00);
                    end else begin
                        buf_q.push_back(8'h00);
                        buf_q.push_back(ch);
                    end
                end
                if ($urandom_range(0, 3) == 0) buf_q.push_back(8'($urandom));
            end
            BUF_NOISE: begin
                repeat (n) buf_q.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
            end
            BUF_BOM: begin
                case ($urandom_range(0, 4))
                    0: buf_q = '{8'hEF, 8'hBB, 8'hBF};
                    1: buf_q = '{8'hFF, 8'hFE, 8'h00, 8'h00};
                    2: buf_q = '{8'h00, 8'h00, 8'hFE, 8'hFF};
                    3: buf_q = '{8'hFF, 8'hFE};
                    default: buf_q = '{8'hFE, 8'hFF};
                endcase
                // sometimes cut the mark short
                if ($urandom_range(0, 4) == 0) buf_q.delete(buf_q.size() - 1);
                push_text($urandom_range(0, 12), 5);
            end
            default: begin
                // can cross the size limit; one stray byte sits near the threshold
                push_text($urandom_range(90, 150), 0);
                buf_q[$urandom_range(4, 60)] = 8'hFF;
            end
        endcase
    endtask

    initial begin
        sb = new();
        quiet[TX] = 0;
        quiet[RX] = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty, marks, cut-short and broken sequences, noise items
        buf_q.delete();
        send_buffer(END_MARKER, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0, draw_gap(TX));
        buf_q = '{8'hFF};
        send_buffer(END_ON_BYTE, 1'b0);
        buf_q = '{8'hEF, 8'hBB, 8'hBF};
        send_buffer(END_ON_BYTE, 1'b0);
        buf_q = '{8'hFF, 8'hFE, 8'h00, 8'h00};
        send_buffer(END_ON_BYTE, 1'b0);
        buf_q = '{8'h00, 8'h00, 8'hFE, 8'hFF};
        send_buffer(END_ON_BYTE, 1'b0);
        buf_q = '{8'hFE, 8'hFF};
        send_buffer(END_ON_BYTE, 1'b0);
        buf_q = '{8'hFF, 8'hFE};
        send_buffer(END_MARKER, 1'b0);
        buf_q = '{8'hC3};
        send_buffer(END_ON_BYTE, 1'b0);
        buf_q = '{8'h00};
        send_buffer(END_ON_BYTE, 1'b0);
        buf_q = '{8'h7F, 8'h80};
        send_buffer(END_ON_BYTE, 1'b0);
        buf_q = '{8'hE2, 8'h41};
        send_buffer(END_ON_BYTE, 1'b0);
        buf_q = '{8'h41};
        send_buffer(END_MARKER, 1'b0);

        while (items_sent < ITEM_TARGET) begin
            if (hold_left == 0 && items_sent >= ITEM_TARGET / 2 &&
                items_sent < ITEM_TARGET / 2 + 60) begin
                // results held back while short buffers keep coming: input must stall
                hold_left = HOLD_CYCLES;
                repeat (24) send_item(8'($urandom), 1'b1, 1'b1, 0);
                s_valid <= 1'b0;
                // then wait for the block to drain completely
                while (sb.pending() != 0) @(posedge aclk);
                @(negedge aclk);
                repeat (DRAIN_CYCLES) @(negedge aclk);
            end
            build_buffer();
            send_buffer(($urandom_range(0, 3) == 0) ? END_MARKER : END_ON_BYTE, 1'b1);
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) sb.note_error("buffers closed but no code came out");

        $display({"%0d items, %0d buffers checked; ",
                  "input stalled %0d cycles under a %0d-cycle hold"},
                 items_sent, sb.checked, stall_cycles, HOLD_CYCLES);
        $display({"codes: unknown %0d, utf8 bom %0d, utf32 le/be %0d/%0d, ",
                  "utf16 le/be %0d/%0d, utf8 %0d, ansi %0d"},
                 sb.code_hits[ENC_UNKNOWN], sb.code_hits[ENC_UTF8_BOM],
                 sb.code_hits[ENC_UTF32LE], sb.code_hits[ENC_UTF32BE],
                 sb.code_hits[ENC_UTF16LE], sb.code_hits[ENC_UTF16BE],
                 sb.code_hits[ENC_UTF8], sb.code_hits[ENC_ANSI]);
        if (sb.errors == 0) begin
            $display("text_encoding_detector_core_tb: done, clean");
        end else begin
            $display("%0d mismatches in total", sb.errors);
            $display("text_encoding_detector_core_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout with %0d codes still owed", sb.pending());
        $display("text_encoding_detector_core_tb: done, errors");
        $finish;
    end

endmodule
